>>> hw/rtl/pngu_pkg.sv
package pngu_pkg;

    localparam int MAX_ROW_BYTES_DEF   = 16384;
    localparam int MAX_PIXEL_BYTES_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd2;

    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_SUB   = 3'd1;
    localparam logic [2:0] FLT_UP    = 3'd2;
    localparam logic [2:0] FLT_AVG   = 3'd3;
    localparam logic [2:0] FLT_PAETH = 3'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_FILTER = 2'd1;
    localparam logic [1:0] ST_EARLY_END  = 2'd2;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] filter;
        logic       first_row;
        logic       last_col;
        logic       fin;
        logic [7:0] data;
        logic [1:0] status;
    } t_item;

endpackage

>>> hw/rtl/pngu_ctl.sv
module pngu_ctl #(
    parameter int MAX_ROW_BYTES   = pngu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = pngu_pkg::MAX_PIXEL_BYTES_DEF,
    parameter int AW              = 14,
    parameter int PW              = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic [7:0]                        i_s_tdata,
    input  logic                              i_s_tlast,
    input  logic                              i_ready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pngu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pngu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_item_valid,
    output pngu_pkg::t_item                   o_item,
    output logic [AW-1:0]                     o_item_col,
    output logic [PW-1:0]                     o_pix_idx
);

    localparam int CW = (AW > 15) ? AW : 15;

    localparam logic [1:0] PH_FILTER = 2'd0;
    localparam logic [1:0] PH_ROW    = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;
    localparam logic [1:0] PH_ERROR  = 2'd3;

    logic [14:0]   r_row_bytes,   n_row_bytes;
    logic [3:0]    r_pixel_bytes, n_pixel_bytes;
    logic [15:0]   r_row_count,   n_row_count;
    logic [AW-1:0] r_col,         n_col;
    logic [15:0]   r_row_idx,     n_row_idx;
    logic [2:0]    r_filter,      n_filter;
    logic [1:0]    r_phase,       n_phase;
    logic          r_first_row,   n_first_row;

    logic          accept;
    logic          restart;
    logic [14:0]   rb_eff;
    logic [15:0]   rc_eff;
    logic [3:0]    pb_m1;
    logic          last_col;
    logic          last_row;
    logic          fin;

    assign accept      = i_s_tvalid && i_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_row_bytes == 15'd0) begin
            rb_eff = 15'd1;
        end else if ((CW+1)'(r_row_bytes) > (CW+1)'(MAX_ROW_BYTES)) begin
            rb_eff = 15'(MAX_ROW_BYTES);
        end else begin
            rb_eff = r_row_bytes;
        end
        rc_eff = (r_row_count == 16'd0) ? 16'd1 : r_row_count;
        if (r_pixel_bytes == 4'd0) begin
            pb_m1 = 4'd0;
        end else if (r_pixel_bytes > 4'(MAX_PIXEL_BYTES)) begin
            pb_m1 = 4'(MAX_PIXEL_BYTES - 1);
        end else begin
            pb_m1 = r_pixel_bytes - 4'd1;
        end
    end

    assign o_pix_idx = pb_m1[PW-1:0];
    assign last_col  = (CW'(r_col) + CW'(1)) == CW'(rb_eff);
    assign last_row  = (r_row_idx + 16'd1) == rc_eff;
    assign fin       = last_col && last_row;

    always_comb begin
        n_row_bytes   = r_row_bytes;
        n_pixel_bytes = r_pixel_bytes;
        n_row_count   = r_row_count;
        n_col         = r_col;
        n_row_idx     = r_row_idx;
        n_filter      = r_filter;
        n_phase       = r_phase;
        n_first_row   = r_first_row;
        restart       = 1'b0;
        o_item_valid  = 1'b0;
        o_item_col    = r_col;
        o_item.kind      = pngu_pkg::KIND_BYTE;
        o_item.filter    = r_filter;
        o_item.first_row = r_first_row;
        o_item.last_col  = last_col;
        o_item.fin       = fin;
        o_item.data      = i_s_tdata;
        o_item.status    = pngu_pkg::ST_OK;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pngu_pkg::REG_ROW_BYTES: begin
                    n_row_bytes = i_cfg_data[14:0];
                    restart     = 1'b1;
                end
                pngu_pkg::REG_PIXEL_BYTES: begin
                    n_pixel_bytes = i_cfg_data[3:0];
                    restart       = 1'b1;
                end
                pngu_pkg::REG_ROW_COUNT: begin
                    n_row_count = i_cfg_data;
                    restart     = 1'b1;
                end
                default: begin
                end
            endcase
            if (restart) begin
                n_col       = '0;
                n_row_idx   = 16'd0;
                n_filter    = pngu_pkg::FLT_NONE;
                n_phase     = PH_FILTER;
                n_first_row = 1'b1;
            end
        end else if (accept) begin
            unique case (r_phase)
                PH_FILTER: begin
                    o_item_valid = 1'b1;
                    if (i_s_tdata > 8'(pngu_pkg::FLT_PAETH)) begin
                        o_item.kind   = pngu_pkg::KIND_ERROR;
                        o_item.status = pngu_pkg::ST_BAD_FILTER;
                        n_phase       = PH_ERROR;
                    end else if (i_s_tlast) begin
                        o_item.kind   = pngu_pkg::KIND_ERROR;
                        o_item.status = pngu_pkg::ST_EARLY_END;
                        n_phase       = PH_ERROR;
                    end else begin
                        o_item.kind = pngu_pkg::KIND_CLEAR;
                        n_filter    = i_s_tdata[2:0];
                        n_col       = '0;
                        n_phase     = PH_ROW;
                    end
                end
                PH_ROW: begin
                    o_item_valid = 1'b1;
                    if (i_s_tlast && !fin) begin
                        o_item.kind   = pngu_pkg::KIND_ERROR;
                        o_item.status = pngu_pkg::ST_EARLY_END;
                        n_phase       = PH_ERROR;
                    end else if (last_col) begin
                        n_col = '0;
                        if (last_row) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_row_idx   = r_row_idx + 16'd1;
                            n_first_row = 1'b0;
                            n_phase     = PH_FILTER;
                        end
                    end else begin
                        n_col = r_col + AW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes   <= 15'd1;
            r_pixel_bytes <= 4'd1;
            r_row_count   <= 16'd1;
            r_col         <= '0;
            r_row_idx     <= 16'd0;
            r_filter      <= pngu_pkg::FLT_NONE;
            r_phase       <= PH_FILTER;
            r_first_row   <= 1'b1;
        end else begin
            r_row_bytes   <= n_row_bytes;
            r_pixel_bytes <= n_pixel_bytes;
            r_row_count   <= n_row_count;
            r_col         <= n_col;
            r_row_idx     <= n_row_idx;
            r_filter      <= n_filter;
            r_phase       <= n_phase;
            r_first_row   <= n_first_row;
        end
    end

endmodule

>>> hw/rtl/pngu_dp.sv
module pngu_dp #(
    parameter int MAX_ROW_BYTES   = pngu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = pngu_pkg::MAX_PIXEL_BYTES_DEF,
    parameter int AW              = 14,
    parameter int PW              = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  pngu_pkg::t_item  i_item,
    input  logic [AW-1:0]    i_item_col,
    input  logic [PW-1:0]    i_pix_idx,
    output logic             o_ready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [15:0]      o_m_tdata,
    output logic             o_m_tlast,
    output logic [1:0]       o_m_tuser
);

    logic [7:0] mem [MAX_ROW_BYTES];

    logic [7:0] r_cur [MAX_PIXEL_BYTES];
    logic [7:0] r_pri [MAX_PIXEL_BYTES];

    logic            r_s1_valid;
    pngu_pkg::t_item r_s1;
    logic [AW-1:0]   r_s1_col;
    logic [7:0]      r_rdata;

    logic       r_o_valid;
    logic [7:0] r_o_pixel;
    logic       r_o_row_done;
    logic       r_o_image_done;
    logic [1:0] r_o_status;

    logic       s1_emit;
    logic       s1_go;
    logic       out_free;
    logic [7:0] a_val;
    logic [7:0] b_val;
    logic [7:0] c_val;
    logic [8:0] ab_sum;
    logic [7:0] pred;
    logic [7:0] recon;

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic [7:0] pa;
        logic [7:0] pb;
        logic [8:0] s;
        logic [8:0] t;
        logic [8:0] pc;
        pa = (b > c) ? (b - c) : (c - b);
        pb = (a > c) ? (a - c) : (c - a);
        s  = {1'b0, a} + {1'b0, b};
        t  = {c, 1'b0};
        pc = (s > t) ? (s - t) : (t - s);
        if ((pa <= pb) && ({1'b0, pa} <= pc)) begin
            return a;
        end else if ({1'b0, pb} <= pc) begin
            return b;
        end
        return c;
    endfunction

    assign s1_emit  = (r_s1.kind != pngu_pkg::KIND_CLEAR);
    assign out_free = !r_o_valid || i_m_tready;
    assign s1_go    = r_s1_valid && (!s1_emit || out_free);
    assign o_ready  = !r_s1_valid || s1_go;

    assign a_val  = r_cur[i_pix_idx];
    assign c_val  = r_pri[i_pix_idx];
    assign b_val  = r_s1.first_row ? 8'd0 : r_rdata;
    assign ab_sum = {1'b0, a_val} + {1'b0, b_val};

    always_comb begin
        case (r_s1.filter)
            pngu_pkg::FLT_SUB:   pred = a_val;
            pngu_pkg::FLT_UP:    pred = b_val;
            pngu_pkg::FLT_AVG:   pred = ab_sum[8:1];
            pngu_pkg::FLT_PAETH: pred = paeth(a_val, b_val, c_val);
            default:             pred = 8'd0;
        endcase
        recon = r_s1.data + pred;
    end

    always_ff @(posedge i_clk) begin
        if (i_item_valid) begin
            r_s1     <= i_item;
            r_s1_col <= i_item_col;
            r_rdata  <= mem[i_item_col];
        end
        if (s1_go && (r_s1.kind == pngu_pkg::KIND_BYTE)) begin
            mem[r_s1_col] <= recon;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            if (r_s1.kind == pngu_pkg::KIND_CLEAR) begin
                for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                    r_cur[i] <= 8'd0;
                    r_pri[i] <= 8'd0;
                end
            end else if (r_s1.kind == pngu_pkg::KIND_BYTE) begin
                for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                    r_cur[i] <= r_cur[i-1];
                    r_pri[i] <= r_pri[i-1];
                end
                r_cur[0] <= recon;
                r_pri[0] <= b_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_emit) begin
            if (r_s1.kind == pngu_pkg::KIND_BYTE) begin
                r_o_pixel      <= recon;
                r_o_row_done   <= r_s1.last_col;
                r_o_image_done <= r_s1.fin;
                r_o_status     <= pngu_pkg::ST_OK;
            end else begin
                r_o_pixel      <= 8'd0;
                r_o_row_done   <= 1'b0;
                r_o_image_done <= 1'b0;
                r_o_status     <= r_s1.status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_item_valid;
            end
            if (s1_go && s1_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {7'd0, r_o_image_done, r_o_pixel};
    assign o_m_tlast  = r_o_row_done;
    assign o_m_tuser  = r_o_status;

endmodule

>>> hw/rtl/png_row_unfilter.sv
// A byte passes the stage-1 register and the output register. Throughput: one input byte
// per cycle unless stalled, filter type bytes included. The prior-row memory is read at
// accept and written one stage later on a separate write port. Input stalls during a
// config write or while a result waits in the output register with one behind it.
// Reset clears all control state; the image geometry returns to one byte, one pixel
// byte and one row. The prior-row memory is not cleared and needs no clearing pass.
module png_row_unfilter #(
    parameter int MAX_ROW_BYTES   = pngu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = pngu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,   // data_byte
    input  logic                             i_s_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [15:0]                      o_m_tdata,   // pixel_byte, image_done, zeros
    output logic                             o_m_tlast,
    output logic [1:0]                       o_m_tuser,   // status
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pngu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pngu_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic            ready;
    logic            item_valid;
    pngu_pkg::t_item item;
    logic [AW-1:0]   item_col;
    logic [PW-1:0]   pix_idx;

    assign o_s_tready = ready && !i_cfg_valid;

    pngu_ctl #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .AW              (AW),
        .PW              (PW)
    ) u_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_ready      (ready),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_item_valid (item_valid),
        .o_item       (item),
        .o_item_col   (item_col),
        .o_pix_idx    (pix_idx)
    );

    pngu_dp #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .AW              (AW),
        .PW              (PW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .i_item_col   (item_col),
        .i_pix_idx    (pix_idx),
        .o_ready      (ready),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tlast    (o_m_tlast),
        .o_m_tuser    (o_m_tuser)
    );

endmodule
